// File: hdl/uart_sync_word_frame_receiver_defines.svh
// ---------------------------------------------------------------------------
// uart_sync_word_frame_receiver_defines.svh
// assertion macros for the sync word frame receiver
// ---------------------------------------------------------------------------
`ifndef UART_SYNC_WORD_FRAME_RECEIVER_DEFINES_SVH
`define UART_SYNC_WORD_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define USWFR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("uswfr same-cycle check failed");

// next-cycle implication, checked out of reset
`define USWFR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("uswfr next-cycle check failed");

`else

`define USWFR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define USWFR_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: hdl/uswfr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uswfr_pkg
// constants and field widths of the sync word frame receiver
// ---------------------------------------------------------------------------
package uswfr_pkg;

    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 6;
    localparam int SYNC_W  = 16;
    localparam int THR_W   = 16;
    localparam int CHAN_W  = 8;

    // result stream widths
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 2;

    // sync words
    localparam logic [SYNC_W-1:0] SYNC_DATA      = 16'hAAAA;
    localparam logic [SYNC_W-1:0] SYNC_HANDSHAKE = 16'hCCCC;
    localparam logic [SYNC_W-1:0] SYNC_AFTER     = 16'h0101;

    // reset values of the radio parameters
    localparam logic [THR_W-1:0]  THR_RESET  = 16'h0001;
    localparam logic [CHAN_W-1:0] CHAN_RESET = 8'h01;

    // payload positions with a fixed meaning in a handshake frame
    localparam logic [INDEX_W-1:0] POS_THR_HI = 6'd0;
    localparam logic [INDEX_W-1:0] POS_THR_LO = 6'd1;
    localparam logic [INDEX_W-1:0] POS_CHAN   = 6'd2;

    // frame kind codes
    typedef enum logic {
        KIND_DATA      = 1'b0,
        KIND_HANDSHAKE = 1'b1
    } frame_kind_t;

endpackage

// File: hdl/uart_sync_word_frame_receiver.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uart_sync_word_frame_receiver
// hunts for a 16-bit sync word in a byte stream and indexes the frame payload
// ---------------------------------------------------------------------------
// channel | dir | ports                      | content
// s_      | in  | tvalid tready tdata[7:0]   | one received byte
// m_      | out | tvalid tready tdata tlast  | one result per byte, tlast on the
//         |     | tuser[1:0]                 | last byte of a data frame
//
// a single update lies between the byte and the
// result register, so one byte is accepted per cycle when m_tready is high.
// the result register holds a result until it is taken; s_tready is high
// whenever it is empty or being emptied in the same cycle.
// aresetn clears sync search, byte count, parameters (threshold and channel
// to one) and mode; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "uart_sync_word_frame_receiver_defines.svh"

module uart_sync_word_frame_receiver #(
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: rx_byte[7:0]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [uswfr_pkg::BYTE_W-1:0]  s_tdata,
    // m_tdata: payload_index[5:0], payload_byte[13:6], standby_threshold[29:14],
    //          channel_number[37:30], handshake_mode[38], zero[39]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [uswfr_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    // m_tuser: payload_valid[0], frame_kind[1]
    output logic [uswfr_pkg::M_USER_W-1:0] m_tuser
);
    import uswfr_pkg::*;

    localparam logic [INDEX_W-1:0] LAST_POS = INDEX_W'(PAYLOAD_BYTES - 1);

    // control state
    logic [SYNC_W-1:0]  sync_reg,  sync_next;
    logic [INDEX_W-1:0] count_reg, count_next;
    logic [THR_W-1:0]   thr_reg,   thr_next;
    logic [CHAN_W-1:0]  chan_reg,  chan_next;
    logic               mode_reg,  mode_next;
    logic               out_valid_reg, out_valid_next;

    // header bytes of a handshake frame, no reset
    logic [BYTE_W-1:0]  hdr_hi_reg, hdr_hi_next;
    logic [BYTE_W-1:0]  hdr_lo_reg, hdr_lo_next;
    logic [CHAN_W-1:0]  chan_hold_reg, chan_hold_next;

    // result payload, no reset
    logic               pvalid_reg, pvalid_next;
    logic [INDEX_W-1:0] pindex_reg, pindex_next;
    logic [BYTE_W-1:0]  pbyte_reg,  pbyte_next;
    logic               done_reg,   done_next;
    frame_kind_t        kind_reg,   kind_next;

    logic s_accept;
    logic in_frame;
    logic is_handshake;
    logic last_byte;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign in_frame     = (sync_reg == SYNC_DATA) || (sync_reg == SYNC_HANDSHAKE);
    assign is_handshake = (sync_reg == SYNC_HANDSHAKE);
    assign last_byte    = (count_reg == LAST_POS);

    // per-byte update of search state, parameters and result
    always_comb begin
        sync_next      = sync_reg;
        count_next     = count_reg;
        thr_next       = thr_reg;
        chan_next      = chan_reg;
        mode_next      = mode_reg;
        hdr_hi_next    = hdr_hi_reg;
        hdr_lo_next    = hdr_lo_reg;
        chan_hold_next = chan_hold_reg;
        pvalid_next    = pvalid_reg;
        pindex_next    = pindex_reg;
        pbyte_next     = pbyte_reg;
        done_next      = done_reg;
        kind_next      = kind_reg;
        out_valid_next = out_valid_reg;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        if (s_accept) begin
            out_valid_next = 1'b1;
            if (in_frame) begin
                pvalid_next = 1'b1;
                pindex_next = count_reg;
                pbyte_next  = s_tdata;
                kind_next   = is_handshake ? KIND_HANDSHAKE : KIND_DATA;
                done_next   = last_byte && !is_handshake;

                // capture handshake header bytes
                if (count_reg == POS_THR_HI) begin
                    hdr_hi_next = s_tdata;
                end
                if (count_reg == POS_THR_LO) begin
                    hdr_lo_next = s_tdata;
                end
                if (count_reg == POS_CHAN) begin
                    chan_hold_next = s_tdata;
                end

                // end of frame: set mode, apply parameters of a handshake frame, restart search
                if (last_byte) begin
                    count_next = '0;
                    sync_next  = SYNC_AFTER;
                    if (is_handshake) begin
                        thr_next  = {hdr_hi_reg, hdr_lo_reg};
                        chan_next = (count_reg == POS_CHAN) ? s_tdata : chan_hold_reg;
                        mode_next = 1'b1;
                    end else begin
                        mode_next = 1'b0;
                    end
                end else begin
                    count_next = count_reg + INDEX_W'(1);
                end
            end else begin
                // hunting: shift byte into sync register
                pvalid_next = 1'b0;
                pindex_next = '0;
                pbyte_next  = '0;
                done_next   = 1'b0;
                kind_next   = KIND_DATA;
                sync_next   = {sync_reg[SYNC_W-BYTE_W-1:0], s_tdata};
                count_next  = '0;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg      <= '0;
            count_reg     <= '0;
            thr_reg       <= THR_RESET;
            chan_reg      <= CHAN_RESET;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            sync_reg      <= sync_next;
            count_reg     <= count_next;
            thr_reg       <= thr_next;
            chan_reg      <= chan_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        hdr_hi_reg    <= hdr_hi_next;
        hdr_lo_reg    <= hdr_lo_next;
        chan_hold_reg <= chan_hold_next;
        pvalid_reg    <= pvalid_next;
        pindex_reg    <= pindex_next;
        pbyte_reg     <= pbyte_next;
        done_reg      <= done_next;
        kind_reg      <= kind_next;
    end

    // result stream; parameters only change when a new result is loaded
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = done_reg;
    assign m_tuser  = {kind_reg, pvalid_reg};
    assign m_tdata  = {1'b0, mode_reg, chan_reg, thr_reg, pbyte_reg, pindex_reg};

    // checks
    `USWFR_ASSERT_IMP(a_done_on_data, aclk, aresetn, m_tvalid && m_tlast, m_tuser[0] && !m_tuser[1])
    `USWFR_ASSERT_IMP(a_ready_when_empty, aclk, aresetn, !out_valid_reg, s_tready)
    `USWFR_ASSERT_IMP(a_count_in_frame, aclk, aresetn, count_reg != '0, in_frame)
    `USWFR_ASSERT_NXT(a_handshake_end, aclk, aresetn, s_accept && is_handshake && last_byte, mode_reg && (sync_reg == SYNC_AFTER))

endmodule
